@@ design/csdc_pkg.sv @@
// Shared types and constants for the chunked stream diff counter.
// No dependencies; the controller, datapath and top refer to this package.
`default_nettype none

package csdc_pkg;

    localparam int CNT_W   = 25;          // per-chunk counts and chunk size
    localparam int IDX_W   = 24;          // chunk index and kind counters
    localparam int PCT_W   = 7;           // percent, 0..100
    localparam int NUM_W   = CNT_W + PCT_W;
    localparam int STEP_W  = 3;           // divider step index
    localparam int KIND_W  = 2;

    localparam logic [CNT_W-1:0] CHUNK_RESET = CNT_W'(1024 * 1024);

    // chunk kinds
    localparam logic [KIND_W-1:0] K_EQUAL   = 2'd0;
    localparam logic [KIND_W-1:0] K_CHANGED = 2'd1;
    localparam logic [KIND_W-1:0] K_GROWN   = 2'd2;
    localparam logic [KIND_W-1:0] K_SHRUNK  = 2'd3;

    // configuration register indexes
    localparam logic REG_CHUNK_SIZE   = 1'b0;
    localparam logic REG_REPORT_EQUAL = 1'b1;

    // controller to datapath
    typedef struct packed {
        logic              in_ready;
        logic              mul_start;
        logic              div_step;
        logic [STEP_W-1:0] step_idx;
        logic              out_load;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic close_emit;     // word accepted that closes a reported chunk
        logic close_changed;  // that chunk is a changed one
        logic out_free;       // output register can take a result now
    } t_stat;

endpackage

`default_nettype wire

@@ design/csdc_in_if.sv @@
// Input channel: one stream position per word.
// Depends on nothing.
`default_nettype none

interface csdc_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] old_byte;
    logic       old_valid;
    logic [7:0] new_byte;
    logic       new_valid;
    logic       final_req;

    modport source (output valid, old_byte, old_valid, new_byte, new_valid, final_req,
                    input ready);
    modport sink   (input valid, old_byte, old_valid, new_byte, new_valid, final_req,
                    output ready);
endinterface

`default_nettype wire

@@ design/csdc_out_if.sv @@
// Output channel: one closed-chunk report per word.
// Byte totals are TOTAL_WIDTH bits wide.
`default_nettype none

interface csdc_out_if #(
    parameter int TOTAL_WIDTH = 48
);
    logic                   valid;
    logic                   ready;
    logic [23:0]            chunk_index;
    logic [1:0]             kind;
    logic [24:0]            diff_count;
    logic [24:0]            compared_bytes;
    logic [6:0]             percent;
    logic [23:0]            equal_chunks;
    logic [23:0]            changed_chunks;
    logic [23:0]            grown_chunks;
    logic [23:0]            shrunk_chunks;
    logic [TOTAL_WIDTH-1:0] common_bytes;
    logic [TOTAL_WIDTH-1:0] changed_bytes;
    logic                   last;

    modport source (output valid, chunk_index, kind, diff_count, compared_bytes, percent,
                    equal_chunks, changed_chunks, grown_chunks, shrunk_chunks,
                    common_bytes, changed_bytes, last,
                    input ready);
    modport sink   (input valid, chunk_index, kind, diff_count, compared_bytes, percent,
                    equal_chunks, changed_chunks, grown_chunks, shrunk_chunks,
                    common_bytes, changed_bytes, last,
                    output ready);
endinterface

`default_nettype wire

@@ design/csdc_ctrl.sv @@
// Controller: sequences chunk close, percent divide and result load.
// Depends on csdc_pkg.
`default_nettype none

module csdc_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  csdc_pkg::t_stat    i_stat,
    output csdc_pkg::t_cmd     o_cmd
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_MUL  = 2'd1;
    localparam logic [1:0] S_DIV  = 2'd2;
    localparam logic [1:0] S_LOAD = 2'd3;

    localparam logic [csdc_pkg::STEP_W-1:0] STEP_TOP =
        csdc_pkg::STEP_W'(csdc_pkg::PCT_W - 1);

    logic [1:0]                   r_state, n_state;
    logic [csdc_pkg::STEP_W-1:0]  r_step, n_step;

    always_comb begin
        n_state = r_state;
        n_step  = r_step;
        o_cmd   = '0;
        o_cmd.step_idx = r_step;
        unique case (r_state)
            S_IDLE: begin
                o_cmd.in_ready = 1'b1;
                if (i_stat.close_emit) begin
                    n_state = i_stat.close_changed ? S_MUL : S_LOAD;
                end
            end
            S_MUL: begin
                o_cmd.mul_start = 1'b1;
                n_step  = STEP_TOP;
                n_state = S_DIV;
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (r_step == '0) begin
                    n_state = S_LOAD;
                end else begin
                    n_step = r_step - 1'b1;
                end
            end
            S_LOAD: begin
                if (i_stat.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_step  <= '0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
        end
    end

endmodule

`default_nettype wire

@@ design/csdc_datapath.sv @@
// Datapath: chunk accumulators, running totals, percent divider, output register.
// Depends on csdc_pkg, csdc_in_if and csdc_out_if.
`default_nettype none

module csdc_datapath #(
    parameter int MAX_CHUNK   = 16777216,
    parameter int TOTAL_WIDTH = 48
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cfg_we,
    input  wire logic                          i_cfg_idx,
    input  wire logic [csdc_pkg::CNT_W-1:0]    i_cfg_data,
    input  csdc_pkg::t_cmd                     i_cmd,
    output csdc_pkg::t_stat                    o_stat,
    csdc_in_if.sink                            i_item,
    csdc_out_if.source                         o_result
);

    localparam int CW = csdc_pkg::CNT_W;
    localparam int IW = csdc_pkg::IDX_W;
    localparam int TW = TOTAL_WIDTH;
    localparam int NW = csdc_pkg::NUM_W;
    localparam int PW = csdc_pkg::PCT_W;
    localparam int KW = csdc_pkg::KIND_W;
    localparam logic [CW-1:0] MAX_SIZE = CW'(MAX_CHUNK);

    // configuration
    logic [CW-1:0] r_cfg_size;
    logic          r_cfg_req;

    // stream state
    logic [CW-1:0] r_pos, r_diffs, r_cmp;
    logic          r_old_short, r_new_short, r_old_end, r_new_end;
    logic [IW-1:0] r_chunk_no;
    logic [IW-1:0] r_kcnt [4];
    logic [TW-1:0] r_tot_common, r_tot_changed;

    // closed chunk snapshot
    logic [IW-1:0] r_s_index;
    logic [KW-1:0] r_s_kind;
    logic [CW-1:0] r_s_diff, r_s_cmp;
    logic [IW-1:0] r_s_kcnt [4];
    logic [TW-1:0] r_s_common, r_s_changed;
    logic          r_s_last;

    // percent divider
    logic [NW-1:0] r_num;
    logic [PW-1:0] r_q;

    // output register
    logic          r_o_valid;
    logic [IW-1:0] r_o_index;
    logic [KW-1:0] r_o_kind;
    logic [CW-1:0] r_o_diff, r_o_cmp;
    logic [PW-1:0] r_o_pct;
    logic [IW-1:0] r_o_kcnt [4];
    logic [TW-1:0] r_o_common, r_o_changed;
    logic          r_o_last;

    logic          fire, op, np, both, differ, close, any_end, emit;
    logic [CW-1:0] limit, pos_n, diffs_n, cmp_n, snap_diff, snap_cmp;
    logic [KW-1:0] kind_c;
    logic [3:0]    bump;
    logic [IW-1:0] n_kcnt [4];
    logic [TW:0]   sum_common, sum_changed;
    logic [TW-1:0] n_tot_common, n_tot_changed;
    logic [NW-1:0] trial, num_mul;

    assign fire = i_item.valid && i_cmd.in_ready;
    assign i_item.ready = i_cmd.in_ready;

    always_comb begin
        if (r_cfg_size == '0) begin
            limit = CW'(1);
        end else if (r_cfg_size > MAX_SIZE) begin
            limit = MAX_SIZE;
        end else begin
            limit = r_cfg_size;
        end
    end

    // a stream that already ended counts as absent
    assign op      = i_item.old_valid && !r_old_end;
    assign np      = i_item.new_valid && !r_new_end;
    assign both    = op && np;
    assign differ  = both && (i_item.old_byte != i_item.new_byte);
    assign pos_n   = r_pos + 1'b1;
    assign diffs_n = r_diffs + CW'(differ);
    assign cmp_n   = r_cmp + CW'(both);
    assign close   = i_item.final_req || (pos_n >= limit);
    assign any_end = r_old_end || r_new_end;

    always_comb begin
        bump = '0;
        if (any_end) begin
            kind_c = r_new_end ? csdc_pkg::K_SHRUNK : csdc_pkg::K_GROWN;
            bump[csdc_pkg::K_GROWN]  = r_old_end;
            bump[csdc_pkg::K_SHRUNK] = r_new_end;
        end else if (diffs_n == '0) begin
            kind_c = csdc_pkg::K_EQUAL;
            bump[csdc_pkg::K_EQUAL] = 1'b1;
        end else begin
            kind_c = csdc_pkg::K_CHANGED;
            bump[csdc_pkg::K_CHANGED] = 1'b1;
        end
    end

    assign snap_diff = any_end ? '0 : diffs_n;
    assign snap_cmp  = any_end ? '0 : cmp_n;
    assign emit = (kind_c != csdc_pkg::K_EQUAL) || r_cfg_req || i_item.final_req;

    always_comb begin
        for (int k = 0; k < 4; k++) begin
            n_kcnt[k] = r_kcnt[k];
            if (bump[k] && (r_kcnt[k] != '1)) begin
                n_kcnt[k] = r_kcnt[k] + 1'b1;
            end
        end
    end

    // saturating totals: carry out means the cap was passed
    assign sum_common  = {1'b0, r_tot_common} +
                         (bump[csdc_pkg::K_EQUAL] ? (TW+1)'(cmp_n) : '0);
    assign sum_changed = {1'b0, r_tot_changed} +
                         (bump[csdc_pkg::K_CHANGED] ? (TW+1)'(diffs_n) : '0);
    assign n_tot_common  = sum_common[TW]  ? '1 : sum_common[TW-1:0];
    assign n_tot_changed = sum_changed[TW] ? '1 : sum_changed[TW-1:0];

    assign o_stat.close_emit    = fire && close && emit;
    assign o_stat.close_changed = (kind_c == csdc_pkg::K_CHANGED);
    assign o_stat.out_free      = !r_o_valid || o_result.ready;

    // diff * 100 by shifts, then restoring division one quotient bit a step
    assign num_mul = (NW'(r_s_diff) << 6) + (NW'(r_s_diff) << 5) + (NW'(r_s_diff) << 2);
    assign trial   = NW'(r_s_cmp) << i_cmd.step_idx;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_size    <= csdc_pkg::CHUNK_RESET;
            r_cfg_req     <= 1'b1;
            r_pos         <= '0;
            r_diffs       <= '0;
            r_cmp         <= '0;
            r_old_short   <= 1'b0;
            r_new_short   <= 1'b0;
            r_old_end     <= 1'b0;
            r_new_end     <= 1'b0;
            r_chunk_no    <= '0;
            r_tot_common  <= '0;
            r_tot_changed <= '0;
            for (int k = 0; k < 4; k++) begin
                r_kcnt[k] <= '0;
            end
            r_o_valid     <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    csdc_pkg::REG_CHUNK_SIZE:   r_cfg_size <= i_cfg_data;
                    csdc_pkg::REG_REPORT_EQUAL: r_cfg_req  <= i_cfg_data[0];
                    default: ;
                endcase
            end

            if (fire) begin
                if (!close) begin
                    r_pos       <= pos_n;
                    r_diffs     <= diffs_n;
                    r_cmp       <= cmp_n;
                    r_old_short <= r_old_short || !op;
                    r_new_short <= r_new_short || !np;
                end else begin
                    r_pos       <= '0;
                    r_diffs     <= '0;
                    r_cmp       <= '0;
                    r_old_short <= 1'b0;
                    r_new_short <= 1'b0;
                    if (i_item.final_req) begin
                        // end of comparison: back to a fresh start
                        r_old_end     <= 1'b0;
                        r_new_end     <= 1'b0;
                        r_chunk_no    <= '0;
                        r_tot_common  <= '0;
                        r_tot_changed <= '0;
                        for (int k = 0; k < 4; k++) begin
                            r_kcnt[k] <= '0;
                        end
                    end else begin
                        r_old_end     <= r_old_end || r_old_short || !op;
                        r_new_end     <= r_new_end || r_new_short || !np;
                        r_chunk_no    <= r_chunk_no + 1'b1;
                        r_tot_common  <= n_tot_common;
                        r_tot_changed <= n_tot_changed;
                        for (int k = 0; k < 4; k++) begin
                            r_kcnt[k] <= n_kcnt[k];
                        end
                    end
                end
            end

            if (i_cmd.out_load) begin
                r_o_valid <= 1'b1;
            end else if (o_result.ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (fire && close) begin
            r_s_index   <= r_chunk_no;
            r_s_kind    <= kind_c;
            r_s_diff    <= snap_diff;
            r_s_cmp     <= snap_cmp;
            r_s_common  <= n_tot_common;
            r_s_changed <= n_tot_changed;
            r_s_last    <= i_item.final_req;
            for (int k = 0; k < 4; k++) begin
                r_s_kcnt[k] <= n_kcnt[k];
            end
            r_q <= '0;
        end else if (i_cmd.mul_start) begin
            r_num <= num_mul;
            r_q   <= '0;
        end else if (i_cmd.div_step) begin
            if (r_num >= trial) begin
                r_num <= r_num - trial;
                r_q[i_cmd.step_idx] <= 1'b1;
            end
        end

        if (i_cmd.out_load) begin
            r_o_index   <= r_s_index;
            r_o_kind    <= r_s_kind;
            r_o_diff    <= r_s_diff;
            r_o_cmp     <= r_s_cmp;
            r_o_pct     <= r_q;
            r_o_common  <= r_s_common;
            r_o_changed <= r_s_changed;
            r_o_last    <= r_s_last;
            for (int k = 0; k < 4; k++) begin
                r_o_kcnt[k] <= r_s_kcnt[k];
            end
        end
    end

    assign o_result.valid          = r_o_valid;
    assign o_result.chunk_index    = r_o_index;
    assign o_result.kind           = r_o_kind;
    assign o_result.diff_count     = r_o_diff;
    assign o_result.compared_bytes = r_o_cmp;
    assign o_result.percent        = r_o_pct;
    assign o_result.equal_chunks   = r_o_kcnt[csdc_pkg::K_EQUAL];
    assign o_result.changed_chunks = r_o_kcnt[csdc_pkg::K_CHANGED];
    assign o_result.grown_chunks   = r_o_kcnt[csdc_pkg::K_GROWN];
    assign o_result.shrunk_chunks  = r_o_kcnt[csdc_pkg::K_SHRUNK];
    assign o_result.common_bytes   = r_o_common;
    assign o_result.changed_bytes  = r_o_changed;
    assign o_result.last           = r_o_last;

endmodule

`default_nettype wire

@@ design/chunked_stream_diff_counter_top.sv @@
// Chunked stream diff counter. Throughput: one position word per cycle inside a chunk.
// Closing a reported chunk holds off input for a load (equal, grown, shrunk) or
// for a multiply, 7 divider steps for percent and a load (changed),
// plus any wait for the output register to drain. The result goes valid when the
// output register loads the closed-chunk snapshot. Synchronous active-low reset restores
// chunk size 1048576, report_equal 1 and clears all stream state and totals.
`default_nettype none

module chunked_stream_diff_counter_top #(
    parameter int MAX_CHUNK   = 16777216,
    parameter int TOTAL_WIDTH = 48
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cfg_we,
    input  wire logic                          i_cfg_idx,
    input  wire logic [csdc_pkg::CNT_W-1:0]    i_cfg_data,
    csdc_in_if.sink                            i_item,
    csdc_out_if.source                         o_result
);

    csdc_pkg::t_cmd  cmd;
    csdc_pkg::t_stat stat;

    csdc_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_stat  (stat),
        .o_cmd   (cmd)
    );

    csdc_datapath #(
        .MAX_CHUNK   (MAX_CHUNK),
        .TOTAL_WIDTH (TOTAL_WIDTH)
    ) u_datapath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_cmd      (cmd),
        .o_stat     (stat),
        .i_item     (i_item),
        .o_result   (o_result)
    );

endmodule

`default_nettype wire

@@ test/tb.sv @@
`timescale 1ns / 100ps
// Self-checking bench for chunked_stream_diff_counter_top: random valid/ready gaps on both sides.
// A built-in chunk tally predicts every report. Uses csdc_pkg, csdc_in_if, csdc_out_if.

module tb;

    localparam int TOT_W        = 48;
    localparam int CW           = csdc_pkg::CNT_W;
    localparam int MAX_CHUNK    = 16777216;
    localparam int LIMIT_CYCLES = 400000;
    localparam int SETTLE       = 12;
    localparam int T_COMMON     = 0;
    localparam int T_CHANGED    = 1;

    typedef struct packed {
        logic [7:0] old_byte;
        logic       old_valid;
        logic [7:0] new_byte;
        logic       new_valid;
        logic       final_req;
    } t_pos;

    typedef struct packed {
        logic [23:0]      chunk_index;
        logic [1:0]       kind;
        logic [24:0]      diff_count;
        logic [24:0]      compared_bytes;
        logic [6:0]       percent;
        logic [23:0]      equal_chunks;
        logic [23:0]      changed_chunks;
        logic [23:0]      grown_chunks;
        logic [23:0]      shrunk_chunks;
        logic [TOT_W-1:0] common_bytes;
        logic [TOT_W-1:0] changed_bytes;
        logic             last;
    } t_report;

    logic              i_clk = 1'b0;
    logic              i_rst_n;
    logic              cfg_we;
    logic              cfg_idx;
    logic [CW-1:0]     cfg_data;

    csdc_in_if                         in_bus();
    csdc_out_if #(.TOTAL_WIDTH(TOT_W)) res_bus();

    chunked_stream_diff_counter_top #(
        .MAX_CHUNK  (MAX_CHUNK),
        .TOTAL_WIDTH(TOT_W)
    ) i_dut (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg_we  (cfg_we),
        .i_cfg_idx (cfg_idx),
        .i_cfg_data(cfg_data),
        .i_item    (in_bus),
        .o_result  (res_bus)
    );

    always #5 i_clk = ~i_clk;

    t_pos    word_queue[$];
    t_report pending_reports[$];
    int      words_queued;
    int      words_taken;
    int      mismatches;
    int      cycles;

    // quiet window: no gaps on either side
    wire calm = (words_taken >= 300) && (words_taken < 520);

    // predicted block state
    logic [24:0]      cfg_chunk;
    logic             cfg_report_eq;
    int unsigned      pos_in_chunk;
    logic [24:0]      chunk_diffs;
    logic [24:0]      chunk_cmp;
    logic             old_short;
    logic             new_short;
    logic             old_ended;
    logic             new_ended;
    logic [23:0]      chunk_num;
    logic [23:0]      kind_tally[4];
    logic [TOT_W-1:0] byte_tally[2];

    task automatic clear_tally();
        pos_in_chunk = 0;
        chunk_diffs  = '0;
        chunk_cmp    = '0;
        old_short    = 1'b0;
        new_short    = 1'b0;
        old_ended    = 1'b0;
        new_ended    = 1'b0;
        chunk_num    = '0;
        foreach (kind_tally[k]) kind_tally[k] = '0;
        foreach (byte_tally[t]) byte_tally[t] = '0;
    endtask

    task automatic bump_kind(input logic [1:0] k);
        if (kind_tally[k] != '1) kind_tally[k] = kind_tally[k] + 1'b1;
    endtask

    task automatic add_bytes(input int t, input logic [24:0] v);
        logic [TOT_W:0] s;
        s = {1'b0, byte_tally[t]} + v;
        byte_tally[t] = s[TOT_W] ? '1 : s[TOT_W-1:0];
    endtask

    // one accepted position; queues the report of the chunk it closes, if any
    task automatic tally_position(input t_pos w);
        logic        op;
        logic        np;
        logic [1:0]  k;
        logic [24:0] dif;
        logic [24:0] cmp;
        logic [6:0]  pct;
        int unsigned lim;
        t_report     r;
        op  = w.old_valid && !old_ended;
        np  = w.new_valid && !new_ended;
        dif = '0;
        cmp = '0;
        pct = '0;
        pos_in_chunk++;
        if (!op) old_short = 1'b1;
        if (!np) new_short = 1'b1;
        if (op && np) begin
            chunk_cmp = chunk_cmp + 1'b1;
            if (w.old_byte != w.new_byte) chunk_diffs = chunk_diffs + 1'b1;
        end
        if (cfg_chunk == 0) lim = 1;
        else if (cfg_chunk > MAX_CHUNK) lim = MAX_CHUNK;
        else lim = cfg_chunk;
        if (!w.final_req && pos_in_chunk < lim) return;

        if (old_ended || new_ended) begin
            k = new_ended ? csdc_pkg::K_SHRUNK : csdc_pkg::K_GROWN;
            if (old_ended) bump_kind(csdc_pkg::K_GROWN);
            if (new_ended) bump_kind(csdc_pkg::K_SHRUNK);
        end else begin
            dif = chunk_diffs;
            cmp = chunk_cmp;
            if (dif == 0) begin
                k = csdc_pkg::K_EQUAL;
                bump_kind(csdc_pkg::K_EQUAL);
                add_bytes(T_COMMON, cmp);
            end else begin
                k = csdc_pkg::K_CHANGED;
                bump_kind(csdc_pkg::K_CHANGED);
                add_bytes(T_CHANGED, dif);
                pct = 7'((64'(dif) * 100) / cmp);
            end
        end

        if (k != csdc_pkg::K_EQUAL || cfg_report_eq || w.final_req) begin
            r.chunk_index    = chunk_num;
            r.kind           = k;
            r.diff_count     = dif;
            r.compared_bytes = cmp;
            r.percent        = pct;
            r.equal_chunks   = kind_tally[csdc_pkg::K_EQUAL];
            r.changed_chunks = kind_tally[csdc_pkg::K_CHANGED];
            r.grown_chunks   = kind_tally[csdc_pkg::K_GROWN];
            r.shrunk_chunks  = kind_tally[csdc_pkg::K_SHRUNK];
            r.common_bytes   = byte_tally[T_COMMON];
            r.changed_bytes  = byte_tally[T_CHANGED];
            r.last           = w.final_req;
            pending_reports.push_back(r);
        end

        if (w.final_req) begin
            clear_tally();
        end else begin
            chunk_num = chunk_num + 1'b1;
            if (old_short) old_ended = 1'b1;
            if (new_short) new_ended = 1'b1;
            pos_in_chunk = 0;
            chunk_diffs  = '0;
            chunk_cmp    = '0;
            old_short    = 1'b0;
            new_short    = 1'b0;
        end
    endtask

    task automatic log_mismatch(input string msg);
        mismatches++;
        if (mismatches <= 10) $display("%s", msg);
    endtask

    // driver
    always @(posedge i_clk) begin : drive_words
        t_pos w;
        if (!i_rst_n) begin
            in_bus.valid <= 1'b0;
        end else begin
            if (in_bus.valid && in_bus.ready) begin
                w.old_byte  = in_bus.old_byte;
                w.old_valid = in_bus.old_valid;
                w.new_byte  = in_bus.new_byte;
                w.new_valid = in_bus.new_valid;
                w.final_req = in_bus.final_req;
                tally_position(w);
                words_taken++;
            end
            if (!in_bus.valid || in_bus.ready) begin
                if (word_queue.size() != 0 && (calm || $urandom_range(0, 99) >= 23)) begin
                    w = word_queue.pop_front();
                    in_bus.valid     <= 1'b1;
                    in_bus.old_byte  <= w.old_byte;
                    in_bus.old_valid <= w.old_valid;
                    in_bus.new_byte  <= w.new_byte;
                    in_bus.new_valid <= w.new_valid;
                    in_bus.final_req <= w.final_req;
                end else begin
                    in_bus.valid <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin : check_reports
        t_report got;
        t_report want;
        if (!i_rst_n) begin
            res_bus.ready <= 1'b0;
        end else begin
            if (res_bus.valid && res_bus.ready) begin
                got.chunk_index    = res_bus.chunk_index;
                got.kind           = res_bus.kind;
                got.diff_count     = res_bus.diff_count;
                got.compared_bytes = res_bus.compared_bytes;
                got.percent        = res_bus.percent;
                got.equal_chunks   = res_bus.equal_chunks;
                got.changed_chunks = res_bus.changed_chunks;
                got.grown_chunks   = res_bus.grown_chunks;
                got.shrunk_chunks  = res_bus.shrunk_chunks;
                got.common_bytes   = res_bus.common_bytes;
                got.changed_bytes  = res_bus.changed_bytes;
                got.last           = res_bus.last;
                if (pending_reports.size() == 0) begin
                    log_mismatch($sformatf("unexpected report: %p", got));
                end else begin
                    want = pending_reports.pop_front();
                    if (got !== want)
                        log_mismatch($sformatf("report mismatch\n  exp %p\n  got %p", want, got));
                end
            end
            res_bus.ready <= calm || $urandom_range(0, 99) >= 23;
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles >= LIMIT_CYCLES) begin
            $display("tb: failure");
            $finish;
        end
    end

    task automatic push_word(input logic [7:0] ob, input logic ov,
                             input logic [7:0] nb, input logic nv, input logic fin);
        t_pos w;
        w.old_byte  = ob;
        w.old_valid = ov;
        w.new_byte  = nb;
        w.new_valid = nv;
        w.final_req = fin;
        word_queue.push_back(w);
        words_queued++;
    endtask

    task automatic wait_idle();
        do @(negedge i_clk);
        while (word_queue.size() != 0 || in_bus.valid || pending_reports.size() != 0);
        repeat (SETTLE) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic idx, input logic [CW-1:0] data);
        @(posedge i_clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= data;
        if (idx == csdc_pkg::REG_CHUNK_SIZE) cfg_chunk = data;
        else cfg_report_eq = data[0];
        @(posedge i_clk);
        cfg_we <= 1'b0;
    endtask

    function automatic logic [CW-1:0] pick_chunk();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return $urandom_range(0, 1) ? CW'(MAX_CHUNK) : '1;
            2:       return CW'($urandom_range(13, 200));
            default: return CW'($urandom_range(1, 12));
        endcase
    endfunction

    // old and new stream of random lengths, random content, closed by a final word
    task automatic queue_stream();
        int         old_len;
        int         new_len;
        int         span;
        int         diff_rate;
        bit         tail;
        logic [7:0] ob;
        logic [7:0] nb;
        old_len = $urandom_range(0, 40);
        new_len = ($urandom_range(0, 9) < 6) ? old_len : $urandom_range(0, 40);
        span    = (old_len > new_len) ? old_len : new_len;
        tail    = (span == 0) || ($urandom_range(0, 3) == 0);
        case ($urandom_range(0, 4))
            0, 1:    diff_rate = 0;
            2:       diff_rate = 5;
            3:       diff_rate = 30;
            default: diff_rate = 100;
        endcase
        for (int i = 0; i < span; i++) begin
            ob = 8'($urandom_range(0, 255));
            nb = ($urandom_range(0, 99) < diff_rate) ? 8'($urandom_range(0, 255)) : ob;
            push_word(ob, i < old_len, nb, i < new_len, !tail && i == span - 1);
        end
        if (tail)
            push_word(8'($urandom_range(0, 255)), 1'b0, 8'($urandom_range(0, 255)), 1'b0,
                      1'b1);
    endtask

    // fully random words, late byte flags included
    task automatic queue_noise();
        int n;
        n = $urandom_range(1, 20);
        for (int i = 0; i < n; i++)
            push_word(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                      8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                      $urandom_range(0, 9) == 0);
        if ($urandom_range(0, 1))
            push_word(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                      8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 1'b1);
    endtask

    initial begin
        i_rst_n          = 1'b0;
        cfg_we           = 1'b0;
        cfg_idx          = csdc_pkg::REG_CHUNK_SIZE;
        cfg_data         = '0;
        in_bus.valid     = 1'b0;
        in_bus.old_byte  = '0;
        in_bus.old_valid = 1'b0;
        in_bus.new_byte  = '0;
        in_bus.new_valid = 1'b0;
        in_bus.final_req = 1'b0;
        res_bus.ready    = 1'b0;
        words_queued     = 0;
        words_taken      = 0;
        mismatches       = 0;
        cycles           = 0;
        cfg_chunk        = csdc_pkg::CHUNK_RESET;
        cfg_report_eq    = 1'b1;
        clear_tally();
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset defaults: short equal stream closed by final
        push_word(8'h00, 1'b1, 8'h00, 1'b1, 1'b0);
        push_word(8'hFF, 1'b1, 8'hFF, 1'b1, 1'b1);
        wait_idle();
        write_reg(csdc_pkg::REG_CHUNK_SIZE, CW'(4));
        // full changed chunk, then a final word with no bytes -> empty equal chunk
        push_word(8'h00, 1'b1, 8'hFF, 1'b1, 1'b0);
        push_word(8'hFF, 1'b1, 8'h00, 1'b1, 1'b0);
        push_word(8'h55, 1'b1, 8'hAA, 1'b1, 1'b0);
        push_word(8'h33, 1'b1, 8'h33, 1'b1, 1'b0);
        push_word(8'hC3, 1'b0, 8'h3C, 1'b0, 1'b1);
        wait_idle();
        write_reg(csdc_pkg::REG_CHUNK_SIZE, CW'(2));
        // old ends in chunk 0; its later byte flag is ignored -> grown
        push_word(8'h11, 1'b1, 8'h11, 1'b1, 1'b0);
        push_word(8'h22, 1'b0, 8'h22, 1'b1, 1'b0);
        push_word(8'h33, 1'b1, 8'h34, 1'b1, 1'b0);
        push_word(8'h44, 1'b0, 8'h44, 1'b1, 1'b1);
        // new ends first -> shrunk
        push_word(8'h01, 1'b1, 8'h02, 1'b1, 1'b0);
        push_word(8'h03, 1'b1, 8'h03, 1'b0, 1'b0);
        push_word(8'h04, 1'b1, 8'h04, 1'b0, 1'b0);
        push_word(8'h05, 1'b1, 8'h05, 1'b0, 1'b1);
        wait_idle();
        write_reg(csdc_pkg::REG_CHUNK_SIZE, CW'(0));
        write_reg(csdc_pkg::REG_REPORT_EQUAL, CW'(0));
        // equal chunks suppressed except the final one
        push_word(8'h80, 1'b1, 8'h80, 1'b1, 1'b0);
        push_word(8'h80, 1'b1, 8'h7F, 1'b1, 1'b0);
        push_word(8'h01, 1'b1, 8'h01, 1'b1, 1'b1);
        // both streams gone without final
        push_word(8'h00, 1'b0, 8'h00, 1'b0, 1'b0);
        push_word(8'hA5, 1'b1, 8'hA5, 1'b1, 1'b1);
        wait_idle();
        write_reg(csdc_pkg::REG_CHUNK_SIZE, CW'(8));
        write_reg(csdc_pkg::REG_REPORT_EQUAL, CW'(1));
        push_word(8'h10, 1'b1, 8'h10, 1'b1, 1'b0);
        push_word(8'h20, 1'b1, 8'h20, 1'b1, 1'b0);
        push_word(8'h30, 1'b1, 8'h30, 1'b1, 1'b0);
        wait_idle();
        // size drops below the running position: next word closes the chunk
        write_reg(csdc_pkg::REG_CHUNK_SIZE, CW'(2));
        push_word(8'h40, 1'b1, 8'h41, 1'b1, 1'b0);
        push_word(8'h50, 1'b1, 8'h50, 1'b1, 1'b1);
        wait_idle();
        write_reg(csdc_pkg::REG_CHUNK_SIZE, '1);
        push_word(8'h60, 1'b1, 8'h61, 1'b1, 1'b1);

        while (words_queued < 1076) begin
            wait_idle();
            write_reg(csdc_pkg::REG_CHUNK_SIZE, pick_chunk());
            write_reg(csdc_pkg::REG_REPORT_EQUAL, CW'($urandom_range(0, 1)));
            repeat ($urandom_range(2, 5)) begin
                if ($urandom_range(0, 4) == 0) queue_noise();
                else queue_stream();
            end
        end
        wait_idle();

        if (mismatches == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
